/* rtl/core/lfsa_pkg.sv */
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared types, codes and the microprogram of the linked free-list slot
// allocator.
// ----------------------------------------------------------------------------
package lfsa_pkg;

    localparam int SLOT_W         = 10;
    localparam int STATUS_W       = 2;
    localparam int POOL_SLOTS_DEF = 1024;

    typedef enum logic {
        F_ALLOC   = 1'b0,
        F_RELEASE = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_NOT_USED     = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

    // Microprogram step addresses
    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_ALLOC_RD,
        S_ALLOC_COMMIT,
        S_FULL,
        S_REL_INIT,
        S_USED_TEST,
        S_USED_LOAD,
        S_USED_END,
        S_NOT_USED,
        S_FREE_INIT,
        S_FREE_TEST,
        S_FREE_DUP,
        S_FREE_LOAD,
        S_DUP,
        S_INS_USED,
        S_INS_SLOT,
        S_INS_FREE,
        S_DONE
    } t_step;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_NO_IN,
        C_IS_REL,
        C_FREE_EMPTY,
        C_USED_STOP,
        C_NOT_FOUND,
        C_FREE_STOP,
        C_IS_DUP,
        C_OUT_BUSY
    } t_cond;

    // Datapath operations
    typedef enum logic [4:0] {
        A_NOP,
        A_LOAD_IN,
        A_RD_FREE_HEAD,
        A_ALLOC_COMMIT,
        A_SET_FULL,
        A_INIT_USED_WALK,
        A_STEP_USED,
        A_LOAD_CUR,
        A_RD_SLOT,
        A_SET_NOT_USED,
        A_INIT_FREE_WALK,
        A_STEP_FREE,
        A_LOAD_CURF,
        A_SET_DUP,
        A_LINK_USED,
        A_LINK_SLOT,
        A_LINK_FREE,
        A_EMIT
    } t_act;

    // Control word: when cond holds, jump to tgt and do nothing else;
    // otherwise perform act and go to nxt.
    typedef struct packed {
        t_cond cond;
        t_step tgt;
        t_act  act;
        t_step nxt;
    } t_uword;

    // Condition flags from the datapath
    typedef struct packed {
        logic no_in;
        logic is_rel;
        logic free_empty;
        logic used_stop;
        logic not_found;
        logic free_stop;
        logic is_dup;
        logic out_busy;
    } t_conds;

    typedef struct packed {
        logic idle;
        t_act act;
    } t_seq_out;

    function automatic t_uword ucode(input t_step pc);
        t_uword w;
        case (pc)
            S_IDLE:         w = '{C_NO_IN,      S_IDLE,      A_LOAD_IN,        S_DISP};
            S_DISP:         w = '{C_IS_REL,     S_REL_INIT,  A_NOP,            S_ALLOC_RD};
            S_ALLOC_RD:     w = '{C_FREE_EMPTY, S_FULL,      A_RD_FREE_HEAD,   S_ALLOC_COMMIT};
            S_ALLOC_COMMIT: w = '{C_NEVER,      S_IDLE,      A_ALLOC_COMMIT,   S_DONE};
            S_FULL:         w = '{C_NEVER,      S_IDLE,      A_SET_FULL,       S_DONE};
            S_REL_INIT:     w = '{C_NEVER,      S_IDLE,      A_INIT_USED_WALK, S_USED_TEST};
            S_USED_TEST:    w = '{C_USED_STOP,  S_USED_END,  A_STEP_USED,      S_USED_LOAD};
            S_USED_LOAD:    w = '{C_NEVER,      S_IDLE,      A_LOAD_CUR,       S_USED_TEST};
            S_USED_END:     w = '{C_NOT_FOUND,  S_NOT_USED,  A_RD_SLOT,        S_FREE_INIT};
            S_NOT_USED:     w = '{C_NEVER,      S_IDLE,      A_SET_NOT_USED,   S_DONE};
            S_FREE_INIT:    w = '{C_NEVER,      S_IDLE,      A_INIT_FREE_WALK, S_FREE_TEST};
            S_FREE_TEST:    w = '{C_FREE_STOP,  S_INS_USED,  A_NOP,            S_FREE_DUP};
            S_FREE_DUP:     w = '{C_IS_DUP,     S_DUP,       A_STEP_FREE,      S_FREE_LOAD};
            S_FREE_LOAD:    w = '{C_NEVER,      S_IDLE,      A_LOAD_CURF,      S_FREE_TEST};
            S_DUP:          w = '{C_NEVER,      S_IDLE,      A_SET_DUP,        S_DONE};
            S_INS_USED:     w = '{C_NEVER,      S_IDLE,      A_LINK_USED,      S_INS_SLOT};
            S_INS_SLOT:     w = '{C_NEVER,      S_IDLE,      A_LINK_SLOT,      S_INS_FREE};
            S_INS_FREE:     w = '{C_NEVER,      S_IDLE,      A_LINK_FREE,      S_DONE};
            S_DONE:         w = '{C_OUT_BUSY,   S_DONE,      A_EMIT,           S_IDLE};
            default:        w = '{C_NEVER,      S_IDLE,      A_NOP,            S_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/lfsa_ram.sv */
// ----------------------------------------------------------------------------
// lfsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfsa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/lfsa_seq.sv */
// ----------------------------------------------------------------------------
// lfsa_seq
// Step counter and control store: fetches one control word per cycle and
// resolves its conditional jump against the datapath flags.
// ----------------------------------------------------------------------------
module lfsa_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lfsa_pkg::t_conds   i_conds,
    output lfsa_pkg::t_seq_out o_ctl
);

    lfsa_pkg::t_step  r_pc;
    lfsa_pkg::t_step  n_pc;
    lfsa_pkg::t_uword w_word;
    logic             w_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= lfsa_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        w_word = lfsa_pkg::ucode(r_pc);
        case (w_word.cond)
            lfsa_pkg::C_NEVER:      w_taken = 1'b0;
            lfsa_pkg::C_NO_IN:      w_taken = i_conds.no_in;
            lfsa_pkg::C_IS_REL:     w_taken = i_conds.is_rel;
            lfsa_pkg::C_FREE_EMPTY: w_taken = i_conds.free_empty;
            lfsa_pkg::C_USED_STOP:  w_taken = i_conds.used_stop;
            lfsa_pkg::C_NOT_FOUND:  w_taken = i_conds.not_found;
            lfsa_pkg::C_FREE_STOP:  w_taken = i_conds.free_stop;
            lfsa_pkg::C_IS_DUP:     w_taken = i_conds.is_dup;
            lfsa_pkg::C_OUT_BUSY:   w_taken = i_conds.out_busy;
            default:                w_taken = 1'b0;
        endcase
        n_pc      = w_taken ? w_word.tgt : w_word.nxt;
        o_ctl.act = w_taken ? lfsa_pkg::A_NOP : w_word.act;
        o_ctl.idle = (r_pc == lfsa_pkg::S_IDLE);
    end

endmodule

/* rtl/core/linked_free_list_slot_allocator_unit.sv */
// ----------------------------------------------------------------------------
// linked_free_list_slot_allocator_unit
// Slot allocator over one link RAM with a used list and an ordered free list.
// ----------------------------------------------------------------------------
// One request is worked at a time by a microprogrammed sequencer; every list
// step is one read of the link RAM plus one load step, and the free-list walk
// adds a test step. A release walks the used list (newest first) up to the
// slot, then the free list over the free slots below it. A result waits in
// the output register while the next word is accepted. After reset the link
// RAM is initialized by a pass over all POOL_SLOTS entries, during which
// o_stall stays high.
module linked_free_list_slot_allocator_unit #(
    parameter int POOL_SLOTS = lfsa_pkg::POOL_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [lfsa_pkg::SLOT_W-1:0]   i_slot,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lfsa_pkg::STATUS_W-1:0] o_status,
    output logic [lfsa_pkg::SLOT_W-1:0]   o_granted_slot
);

    localparam int LW  = $clog2(POOL_SLOTS);
    localparam int CW  = (LW > lfsa_pkg::SLOT_W) ? LW : lfsa_pkg::SLOT_W;
    localparam logic [LW:0]   POOL_CNT = (LW + 1)'(POOL_SLOTS);
    localparam logic [LW-1:0] LAST_IDX = LW'(POOL_SLOTS - 1);

    // control state
    logic [LW-1:0] r_free_head, n_free_head;
    logic [LW-1:0] r_used_head, n_used_head;
    logic          r_clr_busy,  n_clr_busy;
    logic [LW-1:0] r_clr_idx,   n_clr_idx;
    logic          r_out_valid, n_out_valid;

    // working registers
    lfsa_pkg::t_func       r_func,       n_func;
    logic [lfsa_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [LW-1:0]         r_cur,        n_cur;
    logic [LW-1:0]         r_prev_u,     n_prev_u;
    logic [LW-1:0]         r_cur_f,      n_cur_f;
    logic [LW-1:0]         r_prev_f,     n_prev_f;
    logic [LW-1:0]         r_after,      n_after;
    logic [LW:0]           r_cnt,        n_cnt;
    lfsa_pkg::t_status     r_status,     n_status;
    logic [lfsa_pkg::SLOT_W-1:0] r_granted, n_granted;
    lfsa_pkg::t_status     r_out_status, n_out_status;
    logic [lfsa_pkg::SLOT_W-1:0] r_out_granted, n_out_granted;

    // link RAM port
    logic          ram_we;
    logic [LW-1:0] ram_waddr;
    logic [LW-1:0] ram_wdata;
    logic [LW-1:0] ram_raddr;
    logic [LW-1:0] ram_rdata;

    logic [LW-1:0] w_link;
    logic [LW-1:0] w_slot_addr;
    logic [CW-1:0] w_slot_cmp;

    lfsa_pkg::t_conds   w_conds;
    lfsa_pkg::t_seq_out w_ctl;

    lfsa_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_SLOTS)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    lfsa_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_conds (w_conds),
        .o_ctl   (w_ctl)
    );

    // a link at or past the pool end reads as end of list
    assign w_link      = ({1'b0, ram_rdata} < POOL_CNT) ? ram_rdata : '0;
    assign w_slot_addr = LW'(r_slot);
    assign w_slot_cmp  = CW'(r_slot);

    assign o_stall = !w_ctl.idle || r_clr_busy;

    always_comb begin
        w_conds.no_in      = !i_valid || r_clr_busy;
        w_conds.is_rel     = (r_func == lfsa_pkg::F_RELEASE);
        w_conds.free_empty = (r_free_head == '0);
        w_conds.used_stop  = (r_cur == '0) || (CW'(r_cur) == w_slot_cmp) ||
                             (r_cnt == POOL_CNT);
        w_conds.not_found  = (CW'(r_cur) != w_slot_cmp) || (r_slot == '0);
        w_conds.free_stop  = (r_cur_f == '0) || (r_cnt == POOL_CNT) ||
                             (CW'(r_cur_f) > w_slot_cmp);
        w_conds.is_dup     = (CW'(r_cur_f) == w_slot_cmp);
        w_conds.out_busy   = r_out_valid && i_stall;
    end

    always_comb begin
        n_free_head   = r_free_head;
        n_used_head   = r_used_head;
        n_clr_busy    = r_clr_busy;
        n_clr_idx     = r_clr_idx;
        n_out_valid   = r_out_valid;
        n_func        = r_func;
        n_slot        = r_slot;
        n_cur         = r_cur;
        n_prev_u      = r_prev_u;
        n_cur_f       = r_cur_f;
        n_prev_f      = r_prev_f;
        n_after       = r_after;
        n_cnt         = r_cnt;
        n_status      = r_status;
        n_granted     = r_granted;
        n_out_status  = r_out_status;
        n_out_granted = r_out_granted;
        ram_we        = 1'b0;
        ram_waddr     = r_clr_idx;
        ram_wdata     = '0;
        ram_raddr     = '0;

        // initialize links: entry i points at i+1, the last ends the list
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_wdata = (r_clr_idx == LAST_IDX) ? '0 : r_clr_idx + 1'b1;
            n_clr_idx = r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_IDX) begin
                n_clr_busy = 1'b0;
            end
        end

        // drop the output word once taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (w_ctl.act)
            lfsa_pkg::A_LOAD_IN: begin
                n_func    = lfsa_pkg::t_func'(i_func);
                n_slot    = i_slot;
                n_status  = lfsa_pkg::ST_OK;
                n_granted = '0;
            end
            lfsa_pkg::A_RD_FREE_HEAD: begin
                ram_raddr = r_free_head;
            end
            lfsa_pkg::A_ALLOC_COMMIT: begin
                // pop free head, push it on the used list
                n_free_head = w_link;
                n_used_head = r_free_head;
                n_granted   = lfsa_pkg::SLOT_W'(r_free_head);
                ram_we      = 1'b1;
                ram_waddr   = r_free_head;
                ram_wdata   = r_used_head;
            end
            lfsa_pkg::A_SET_FULL: begin
                n_status = lfsa_pkg::ST_FULL;
            end
            lfsa_pkg::A_INIT_USED_WALK: begin
                n_cur    = r_used_head;
                n_prev_u = '0;
                n_cnt    = '0;
            end
            lfsa_pkg::A_STEP_USED: begin
                ram_raddr = r_cur;
                n_prev_u  = r_cur;
                n_cnt     = r_cnt + 1'b1;
            end
            lfsa_pkg::A_LOAD_CUR: begin
                n_cur = w_link;
            end
            lfsa_pkg::A_RD_SLOT: begin
                ram_raddr = w_slot_addr;
            end
            lfsa_pkg::A_SET_NOT_USED: begin
                n_status = lfsa_pkg::ST_NOT_USED;
            end
            lfsa_pkg::A_INIT_FREE_WALK: begin
                n_after  = w_link;
                n_cur_f  = r_free_head;
                n_prev_f = '0;
                n_cnt    = '0;
            end
            lfsa_pkg::A_STEP_FREE: begin
                ram_raddr = r_cur_f;
                n_prev_f  = r_cur_f;
                n_cnt     = r_cnt + 1'b1;
            end
            lfsa_pkg::A_LOAD_CURF: begin
                n_cur_f = w_link;
            end
            lfsa_pkg::A_SET_DUP: begin
                n_status = lfsa_pkg::ST_ALREADY_FREE;
            end
            lfsa_pkg::A_LINK_USED: begin
                // unlink from the used list
                if (r_prev_u == '0) begin
                    n_used_head = r_after;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_prev_u;
                    ram_wdata = r_after;
                end
            end
            lfsa_pkg::A_LINK_SLOT: begin
                ram_we    = 1'b1;
                ram_waddr = w_slot_addr;
                ram_wdata = r_cur_f;
            end
            lfsa_pkg::A_LINK_FREE: begin
                // insert in address order
                if (r_prev_f == '0) begin
                    n_free_head = w_slot_addr;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_prev_f;
                    ram_wdata = w_slot_addr;
                end
            end
            lfsa_pkg::A_EMIT: begin
                n_out_valid   = 1'b1;
                n_out_status  = r_status;
                n_out_granted = r_granted;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= LW'(1);
            r_used_head <= '0;
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_free_head <= n_free_head;
            r_used_head <= n_used_head;
            r_clr_busy  <= n_clr_busy;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_slot        <= n_slot;
        r_cur         <= n_cur;
        r_prev_u      <= n_prev_u;
        r_cur_f       <= n_cur_f;
        r_prev_f      <= n_prev_f;
        r_after       <= n_after;
        r_cnt         <= n_cnt;
        r_status      <= n_status;
        r_granted     <= n_granted;
        r_out_status  <= n_out_status;
        r_out_granted <= n_out_granted;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_granted_slot = r_out_granted;

endmodule

/* rtl/core/lfsa_chk.sv */
// ----------------------------------------------------------------------------
// lfsa_chk
// Port-level checks for the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module lfsa_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          i_func,
    input logic [lfsa_pkg::SLOT_W-1:0]   i_slot,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [lfsa_pkg::STATUS_W-1:0] o_status,
    input logic [lfsa_pkg::SLOT_W-1:0]   o_granted_slot
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_granted_slot))
        else $error("output word changed while stalled");

    // only a successful allocate carries a slot index
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_granted_slot != '0) |-> (o_status == lfsa_pkg::ST_OK))
        else $error("slot granted with failing status");

    // one request at a time: the input closes right after a word is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second word accepted while busy");

    // a fresh result only appears while a request is being worked
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a request in flight");

    // after an accepted release, a result that rises at the delay below carries no slot
    a_rel_nogrant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_func |=> ##3 !$rose(o_valid) || (o_granted_slot == '0))
        else $error("release returned a slot index");

endmodule

bind linked_free_list_slot_allocator_unit lfsa_chk u_lfsa_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_func         (i_func),
    .i_slot         (i_slot),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_granted_slot (o_granted_slot)
);

/* bench/slot_answer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_answer_checker
// Watches both channels of the slot allocator, keeps its own copy of the
// link store and the two list heads, works out the answer to every accepted
// request and compares each returned word with the oldest answer awaited.
// ----------------------------------------------------------------------------
module slot_answer_checker
    import lfsa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic                i_func,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [SLOT_W-1:0]   i_granted_slot,
    output int                  o_pending,
    output int                  o_errors
);

    typedef struct {
        t_status            status;
        logic [SLOT_W-1:0]  granted;
    } t_answer;

    logic [SLOT_W-1:0] next_slot [POOL_SLOTS];
    int                free_first = 1;
    int                used_first = 0;

    t_answer pending_answers [$];
    int      pending_count = 0;
    int      answer_errors = 0;
    int      answers_seen  = 0;

    assign o_pending = pending_count;
    assign o_errors  = answer_errors;

    // A link at or past the pool end reads as end of list.
    function automatic int follow(input int idx);
        if (idx >= POOL_SLOTS)
            return 0;
        return (int'(next_slot[idx]) < POOL_SLOTS) ? int'(next_slot[idx]) : 0;
    endfunction

    task automatic serve_request(input t_func func, input int slot,
                                 output t_status status, output int grant);
        int  prev_u;
        int  cur_u;
        int  prev_f;
        int  cur_f;
        int  steps;
        int  after;
        bit  dup;
        status = ST_OK;
        grant  = 0;
        prev_u = 0;
        prev_f = 0;
        dup    = 1'b0;
        if (func == F_ALLOC) begin
            if (free_first == 0 || free_first >= POOL_SLOTS) begin
                status = ST_FULL;
            end else begin
                grant             = free_first;
                free_first        = follow(grant);
                next_slot[grant]  = used_first[SLOT_W-1:0];
                used_first        = grant;
            end
        end else begin
            cur_u = (used_first < POOL_SLOTS) ? used_first : 0;
            steps = 0;
            while (cur_u != 0 && cur_u != slot && steps < POOL_SLOTS) begin
                prev_u = cur_u;
                cur_u  = follow(cur_u);
                steps++;
            end
            if (cur_u != slot)
                cur_u = 0;
            if (cur_u == 0 || slot == 0) begin
                status = ST_NOT_USED;
            end else begin
                // free list is ascending: stop at the first entry above the slot
                cur_f = (free_first < POOL_SLOTS) ? free_first : 0;
                steps = 0;
                while (cur_f != 0 && cur_f <= slot && steps < POOL_SLOTS && !dup) begin
                    if (cur_f == slot) begin
                        dup = 1'b1;
                    end else begin
                        prev_f = cur_f;
                        cur_f  = follow(cur_f);
                        steps++;
                    end
                end
                if (dup) begin
                    status = ST_ALREADY_FREE;
                end else begin
                    after = follow(slot);
                    if (prev_u == 0)
                        used_first = after;
                    else
                        next_slot[prev_u] = after[SLOT_W-1:0];
                    next_slot[slot] = cur_f[SLOT_W-1:0];
                    if (prev_f == 0)
                        free_first = slot;
                    else
                        next_slot[prev_f] = slot[SLOT_W-1:0];
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("slot checker: result %0d: %s", answers_seen, what);
        answer_errors++;
    endtask

    always @(posedge i_clk) begin : watch
        t_answer want;
        t_status status;
        int      grant;
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_SLOTS; i++)
                next_slot[i] = (i + 1 < POOL_SLOTS) ? SLOT_W'(i + 1) : '0;
            free_first = 1;
            used_first = 0;
            pending_answers.delete();
        end else begin
            // retire the outgoing word before predicting the incoming one
            if (i_out_valid && !i_out_stall) begin
                answers_seen++;
                if (pending_answers.size() == 0) begin
                    report_mismatch("result word with no answer awaited");
                end else begin
                    want = pending_answers.pop_front();
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  i_status, want.status.name()));
                    if (i_granted_slot !== want.granted)
                        report_mismatch($sformatf("granted slot %0d, expected %0d",
                                                  i_granted_slot, want.granted));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                serve_request(t_func'(i_func), int'(i_slot), status, grant);
                want.status  = status;
                want.granted = grant[SLOT_W-1:0];
                pending_answers.push_back(want);
            end
        end
        pending_count = pending_answers.size();
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and release requests into the slot allocator: a directed
// opening, a fill of the whole pool past full, then a random mix that
// drains and refills it. Both sides idle at random; the checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
    import lfsa_pkg::*;

    localparam int POOL           = POOL_SLOTS_DEF;
    localparam int SLOT_MAX       = (1 << SLOT_W) - 1;
    localparam int RANDOM_WORDS   = 900;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 64;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    t_func             i_func  = F_ALLOC;
    logic [SLOT_W-1:0] i_slot  = '0;
    logic              i_stall = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_granted_slot;

    int pending;
    int errors;

    // slots the stimulus believes allocated; allocation always takes the lowest free
    bit held_slot [POOL];
    int held_count     = 0;
    int send_calm      = 0;
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;
    int quiet_cycles   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    linked_free_list_slot_allocator_unit #(
        .POOL_SLOTS(POOL)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_slot         (i_slot),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot)
    );

    slot_answer_checker #(
        .POOL_SLOTS(POOL)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_func         (i_func),
        .i_slot         (i_slot),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_status       (o_status),
        .i_granted_slot (o_granted_slot),
        .o_pending      (pending),
        .o_errors       (errors)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input t_func func, input int slot);
        int gap;
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else begin
            gap = idle_len();
            if ($urandom_range(0, 49) == 0)
                send_calm = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= func;
        i_slot  <= slot[SLOT_W-1:0];
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic request_alloc();
        int lowest;
        lowest = 0;
        for (int i = POOL - 1; i >= 1; i--)
            if (!held_slot[i])
                lowest = i;
        if (lowest != 0) begin
            held_slot[lowest] = 1'b1;
            held_count++;
        end
        send_word(F_ALLOC, $urandom_range(0, SLOT_MAX));
    endtask

    task automatic request_release(input int slot);
        if (slot > 0 && slot < POOL && held_slot[slot]) begin
            held_slot[slot] = 1'b0;
            held_count--;
        end
        send_word(F_RELEASE, slot);
    endtask

    // topmost picks the highest held slot (short walks), else any held slot
    function automatic int pick_held(input bit topmost);
        int start;
        int idx;
        start = $urandom_range(1, POOL - 1);
        for (int k = 0; k < POOL - 1; k++) begin
            idx = topmost ? POOL - 1 - k : 1 + (start - 1 + k) % (POOL - 1);
            if (held_slot[idx])
                return idx;
        end
        return 0;
    endfunction

    // receiver: random stalls, calm stretches, and one long hold-off on request
    initial begin
        int hold;
        int calm;
        calm = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !long_hold_done) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_done = 1'b1;
                i_stall <= 1'b0;
            end else if (calm > 0) begin
                calm--;
                i_stall <= 1'b0;
            end else begin
                hold = idle_len();
                if (hold > 0) begin
                    i_stall <= 1'b1;
                    repeat (hold) @(negedge i_clk);
                end
                i_stall <= 1'b0;
                if ($urandom_range(0, 39) == 0)
                    calm = $urandom_range(20, 100);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        int roll;
        int alloc_pct;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty pool: nothing to release yet
        request_release(0);
        request_release(POOL - 1);
        request_release(1);
        repeat (4) request_alloc();
        request_release(0);
        // unlink from middle, head and tail of the used list
        request_release(3);
        request_release(4);
        request_release(1);
        request_release(3);
        request_alloc();
        request_alloc();
        request_release(2);
        request_release(3);
        request_release(1);
        request_alloc();
        request_release(10'h155);
        request_release(10'h2AA);
        request_release(10'h200);

        // fill the pool under a long receiver hold-off, then knock on it while full
        long_hold_req = 1'b1;
        while (held_count < POOL - 1)
            request_alloc();
        repeat (3) request_alloc();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            roll      = $urandom_range(0, 99);
            alloc_pct = (held_count > 700) ? 22 : 45;
            if (roll < 6)
                request_release($urandom_range(0, SLOT_MAX));
            else if (roll < 6 + alloc_pct || held_count == 0)
                request_alloc();
            else
                request_release(pick_held($urandom_range(0, 5) != 0));
        end
        i_valid <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lfsa_pkg.sv
rtl/core/lfsa_ram.sv
rtl/core/lfsa_seq.sv
rtl/core/linked_free_list_slot_allocator_unit.sv
rtl/core/lfsa_chk.sv
bench/slot_answer_checker.sv
bench/testbench.sv
